// File: hw/rtl/fssi_pkg.sv
// fssi_pkg: types, constants and command/status structs for the flow speed
// smoother and integrator. No dependencies.
package fssi_pkg;

    localparam int WINDOW_DEF = 10;
    localparam logic [15:0] CENTER_RST   = 16'd1500;
    localparam logic [14:0] DEADBAND_RST = 15'd35;
    localparam logic [19:0] TAU_RST      = 20'd15916;
    localparam int ALPHA_W = 17;
    localparam int DIV_STEPS = 17;

    localparam logic [1:0] REG_CENTER   = 2'd0;
    localparam logic [1:0] REG_DEADBAND = 2'd1;
    localparam logic [1:0] REG_TAU      = 2'd2;

    localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_AVG,
        ST_FILT,
        ST_INTEG,
        ST_OUT
    } fssi_state_t;

    typedef struct packed {
        logic load;
        logic sum_step;
        logic div_step;
        logic avg;
        logic filt;
        logic integ;
        logic emit;
    } fssi_cmd_t;

    typedef struct packed {
        logic skip;
        logic sum_done;
        logic div_done;
        logic out_free;
    } fssi_sts_t;

endpackage

// File: hw/rtl/fssi_ctrl.sv
// fssi_ctrl: sequencing state machine for the smoother datapath.
// Depends on fssi_pkg.
module fssi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fssi_pkg::fssi_sts_t sts,
    output fssi_pkg::fssi_cmd_t cmd
);
    import fssi_pkg::*;

    fssi_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && !sts.skip) state_next = ST_SUM;
            end
            ST_SUM: begin
                if (sts.sum_done) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_AVG;
            end
            ST_AVG:   state_next = ST_FILT;
            ST_FILT:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_OUT;
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SUM:   cmd.sum_step = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_AVG:   cmd.avg = 1'b1;
            ST_FILT:  cmd.filt = 1'b1;
            ST_INTEG: cmd.integ = 1'b1;
            ST_OUT:   cmd.emit = sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/fssi_dpath.sv
// fssi_dpath: window store, serial sum, alpha divider, low-pass, integrator
// and output register. Depends on fssi_pkg.
module fssi_dpath #(
    parameter int WINDOW = fssi_pkg::WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fssi_pkg::fssi_cmd_t cmd,
    output fssi_pkg::fssi_sts_t sts,
    input  logic [31:0]         now_us,
    input  logic signed [15:0]  x_raw,
    input  logic signed [15:0]  y_raw,
    input  logic [15:0]         stick_roll,
    input  logic [15:0]         stick_pitch,
    input  logic [15:0]         cfg_center,
    input  logic [14:0]         cfg_deadband,
    input  logic [19:0]         cfg_tau,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [128:0]        out_word
);
    import fssi_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = 16 + CW;
    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
    localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);
    // reciprocal of the window depth for the average
    localparam int RL = $clog2(WINDOW);
    localparam int RS = SW + RL;
    localparam longint RECIP_L = ((longint'(1) << RS) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
    localparam logic [SW:0] RECIP = (SW+1)'(RECIP_L);

    logic signed [15:0] xw_reg [WINDOW];
    logic signed [15:0] yw_reg [WINDOW];
    logic [IW-1:0] slot_reg;
    logic [31:0] stamp_reg;
    logic stamp_ok_reg;
    logic [31:0] dt_reg;
    logic hold_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [SW-1:0] xs_reg, ys_reg;
    logic [32:0] den_reg;
    logic [16:0] num_reg;
    logic [33:0] rem_reg;
    logic [ALPHA_W-1:0] q_reg;
    logic [4:0] dcnt_reg;
    logic signed [15:0] xa_reg, ya_reg;
    logic signed [15:0] xf_reg, yf_reg;
    logic signed [47:0] xp_reg, yp_reg;
    logic signed [49:0] xpr_reg, ypr_reg;
    logic signed [33:0] xd_reg, yd_reg;
    logic ovalid_reg;
    logic [128:0] oword_reg;

    function automatic logic inside_db(input logic [15:0] stick, input logic [15:0] ctr,
                                       input logic [14:0] db);
        logic signed [16:0] off;
        logic signed [16:0] dbs;
        off = 17'(signed'(stick - ctr));
        dbs = signed'({2'b00, db});
        return (off > -dbs) && (off < dbs);
    endfunction

    function automatic logic signed [15:0] div_win(input logic signed [SW-1:0] s);
        logic [SW-1:0] mag;
        logic [2*SW:0] prod;
        logic [SW-1:0] q;
        mag = s[SW-1] ? SW'(-s) : s;
        prod = (2*SW+1)'(mag) * (2*SW+1)'(RECIP);
        q = SW'(prod >> RS);
        return s[SW-1] ? 16'(-q) : 16'(q);
    endfunction

    function automatic logic signed [15:0] lp(input logic signed [15:0] last,
                                              input logic signed [33:0] d);
        logic [33:0] mag;
        logic signed [16:0] step;
        mag = d[33] ? 34'(-d) : d;
        step = d[33] ? -signed'({1'b0, mag[31:16]}) : signed'({1'b0, mag[31:16]});
        return 16'(17'(last) + step);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'(POS_MAX)) return POS_MAX;
        if (v < 50'(POS_MIN)) return POS_MIN;
        return v[47:0];
    endfunction

    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    assign rem_sh = {rem_reg[32:0], num_reg[16]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign sts.skip = !stamp_ok_reg || (now_us < stamp_reg);
    assign sts.sum_done = (cnt_reg == WIN_CNT);
    assign sts.div_done = (dcnt_reg == DIV_LAST);
    assign sts.out_free = !ovalid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                xw_reg[i] <= '0;
                yw_reg[i] <= '0;
            end
            slot_reg <= '0;
            stamp_reg <= '0;
            stamp_ok_reg <= 1'b0;
            xf_reg <= '0;
            yf_reg <= '0;
            xp_reg <= '0;
            yp_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
            if (cmd.load) begin
                stamp_reg <= now_us;
                stamp_ok_reg <= 1'b1;
                if (!sts.skip) begin
                    dt_reg <= now_us - stamp_reg;
                    xw_reg[slot_reg] <= x_raw;
                    yw_reg[slot_reg] <= y_raw;
                    slot_reg <= (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                    hold_reg <= inside_db(stick_roll, cfg_center, cfg_deadband)
                             && inside_db(stick_pitch, cfg_center, cfg_deadband);
                    cnt_reg <= '0;
                    xs_reg <= '0;
                    ys_reg <= '0;
                    dcnt_reg <= '0;
                end
            end
            if (cmd.sum_step) begin
                if (cnt_reg != WIN_CNT) begin
                    xs_reg <= xs_reg + SW'(xw_reg[cnt_reg[IW-1:0]]);
                    ys_reg <= ys_reg + SW'(yw_reg[cnt_reg[IW-1:0]]);
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    // quotient fits 17 bits, so the upper dividend bits preload the remainder
                    den_reg <= 33'(cfg_tau) + 33'(dt_reg);
                    num_reg <= {dt_reg[0], 16'd0};
                    rem_reg <= 34'(dt_reg[31:1]);
                    q_reg <= '0;
                end
            end
            if (cmd.div_step) begin
                num_reg <= {num_reg[15:0], 1'b0};
                if (!rem_sub[33]) begin
                    rem_reg <= rem_sub;
                    q_reg <= {q_reg[ALPHA_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg <= {q_reg[ALPHA_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.avg) begin
                xa_reg <= div_win(xs_reg);
                ya_reg <= div_win(ys_reg);
            end
            if (cmd.filt) begin
                xd_reg <= signed'({1'b0, (den_reg == '0) ? 17'd0 : q_reg})
                          * (17'(xa_reg) - 17'(xf_reg));
                yd_reg <= signed'({1'b0, (den_reg == '0) ? 17'd0 : q_reg})
                          * (17'(ya_reg) - 17'(yf_reg));
            end
            if (cmd.integ) begin
                xf_reg <= lp(xf_reg, xd_reg);
                yf_reg <= lp(yf_reg, yd_reg);
                xpr_reg <= 50'(xp_reg)
                           + 50'(lp(xf_reg, xd_reg)) * 50'(signed'({1'b0, dt_reg}));
                ypr_reg <= 50'(yp_reg)
                           + 50'(lp(yf_reg, yd_reg)) * 50'(signed'({1'b0, dt_reg}));
            end
            if (cmd.emit) begin
                xp_reg <= hold_reg ? sat48(xpr_reg) : '0;
                yp_reg <= hold_reg ? sat48(ypr_reg) : '0;
                oword_reg <= {hold_reg,
                              hold_reg ? sat48(ypr_reg) : 48'd0,
                              hold_reg ? sat48(xpr_reg) : 48'd0,
                              yf_reg, xf_reg};
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_word = oword_reg;

endmodule

// File: hw/rtl/fssi_regs.sv
// fssi_regs: APB configuration registers for center, deadband and tau.
// Depends on fssi_pkg.
module fssi_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] cfg_center,
    output logic [14:0] cfg_deadband,
    output logic [19:0] cfg_tau
);
    import fssi_pkg::*;

    logic [15:0] center_reg;
    logic [14:0] deadband_reg;
    logic [19:0] tau_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= CENTER_RST;
            deadband_reg <= DEADBAND_RST;
            tau_reg <= TAU_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                REG_CENTER:   center_reg <= pwdata[15:0];
                REG_DEADBAND: deadband_reg <= pwdata[14:0];
                REG_TAU:      tau_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CENTER:   prdata = {16'd0, center_reg};
            REG_DEADBAND: prdata = {17'd0, deadband_reg};
            REG_TAU:      prdata = {12'd0, tau_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg_center = center_reg;
    assign cfg_deadband = deadband_reg;
    assign cfg_tau = tau_reg;

endmodule

// File: hw/rtl/flow_speed_smoother_integrator_core.sv
// flow_speed_smoother_integrator_core: top level of the flow speed smoother.
// Depends on fssi_pkg, fssi_regs, fssi_ctrl and fssi_dpath.
//
// Takes one sample word at a time and answers with one result word, or none
// for the first sample and for a timestamp that went backwards. From its
// acceptance, a sample with a result passes through the running sum over the
// window entries, the bit-serial alpha division, then average, filter,
// integrate and output steps before the next sample can be taken. The
// result sits in an output register, so the next sample is taken once it
// has been loaded; a result still waiting there holds the following one in
// its output step.
module flow_speed_smoother_integrator_core #(
    parameter int WINDOW = fssi_pkg::WINDOW_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_us[31:0], x_raw[47:32], y_raw[63:48], stick_roll[79:64], stick_pitch[95:80]
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_speed[15:0], y_speed[31:16], x_move[79:32], y_move[127:80], holding[128]
    output logic [135:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fssi_pkg::*;

    fssi_cmd_t cmd;
    fssi_sts_t sts;
    logic [15:0] cfg_center;
    logic [14:0] cfg_deadband;
    logic [19:0] cfg_tau;
    logic [128:0] out_word;

    fssi_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .cfg_center, .cfg_deadband, .cfg_tau
    );

    fssi_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .sts, .cmd
    );

    fssi_dpath #(.WINDOW(WINDOW)) u_dpath (
        .aclk, .aresetn, .cmd, .sts,
        .now_us(s_tdata[31:0]),
        .x_raw(s_tdata[47:32]),
        .y_raw(s_tdata[63:48]),
        .stick_roll(s_tdata[79:64]),
        .stick_pitch(s_tdata[95:80]),
        .cfg_center, .cfg_deadband, .cfg_tau,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_word
    );

    assign m_tdata = {7'd0, out_word};

endmodule

// File: tb/tb_flow_speed_smoother_integrator_core.sv
// tb_flow_speed_smoother_integrator_core: self-checking bench for the flow speed
// smoother and integrator, predicting every result word from the accepted samples.
// Depends on fssi_pkg and flow_speed_smoother_integrator_core.
module tb_flow_speed_smoother_integrator_core;
    import fssi_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic signed [15:0] x_speed;
        logic signed [15:0] y_speed;
        logic signed [47:0] x_move;
        logic signed [47:0] y_move;
        logic               holding;
    } flow_result_t;

    class speed_scoreboard;
        logic [15:0] center;
        logic [14:0] deadband;
        logic [19:0] tau_us;
        int          x_hist[WINDOW_DEF];
        int          y_hist[WINDOW_DEF];
        int          slot;
        logic [31:0] stamp;
        bit          stamped;
        int          x_filt;
        int          y_filt;
        longint      x_pos;
        longint      y_pos;
        flow_result_t pending[$];
        int          errors;
        int          checked;
        int          holds;

        function new();
            center = CENTER_RST;
            deadband = DEADBAND_RST;
            tau_us = TAU_RST;
            foreach (x_hist[i]) begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            slot = 0;
            stamp = 0;
            stamped = 0;
            x_filt = 0;
            y_filt = 0;
            x_pos = 0;
            y_pos = 0;
            errors = 0;
            checked = 0;
            holds = 0;
        endfunction

        function int hist_mean(int h[WINDOW_DEF]);
            longint sum;
            sum = 0;
            foreach (h[i]) sum += h[i];
            return int'(sum / WINDOW_DEF);
        endfunction

        function int smooth(int prev, int target, longint alpha);
            longint d;
            d = alpha * longint'(target - prev);
            return prev + int'(d / 65536);
        endfunction

        function longint accumulate(longint pos, int speed, logic [31:0] dt);
            longint s;
            s = pos + longint'(speed) * longint'({32'd0, dt});
            if (s > longint'(POS_MAX)) s = POS_MAX;
            if (s < longint'(POS_MIN)) s = POS_MIN;
            return s;
        endfunction

        function bit centered(logic [15:0] stick);
            logic [15:0] d;
            int off;
            d = stick - center;
            off = int'($signed(d));
            return off > -int'(deadband) && off < int'(deadband);
        endfunction

        function void note_sample(logic [95:0] w);
            logic [31:0] now;
            logic [31:0] dt;
            longint den;
            longint alpha;
            flow_result_t r;
            now = w[31:0];
            if (!stamped || now < stamp) begin
                stamp = now;
                stamped = 1;
                return;
            end
            dt = now - stamp;
            stamp = now;
            x_hist[slot] = int'($signed(w[47:32]));
            y_hist[slot] = int'($signed(w[63:48]));
            slot = (slot + 1) % WINDOW_DEF;
            den = longint'(tau_us) + longint'({32'd0, dt});
            alpha = (den == 0) ? 0 : (longint'({32'd0, dt}) <<< 16) / den;
            x_filt = smooth(x_filt, hist_mean(x_hist), alpha);
            y_filt = smooth(y_filt, hist_mean(y_hist), alpha);
            r.holding = centered(w[79:64]) && centered(w[95:80]);
            if (r.holding) begin
                x_pos = accumulate(x_pos, x_filt, dt);
                y_pos = accumulate(y_pos, y_filt, dt);
                holds++;
            end else begin
                x_pos = 0;
                y_pos = 0;
            end
            r.x_speed = x_filt[15:0];
            r.y_speed = y_filt[15:0];
            r.x_move = x_pos[47:0];
            r.y_move = y_pos[47:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [135:0] w);
            flow_result_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w[15:0] !== e.x_speed) begin
                $error("x_speed: expected %0d, got %0d", e.x_speed, $signed(w[15:0]));
                errors++;
            end
            if (w[31:16] !== e.y_speed) begin
                $error("y_speed: expected %0d, got %0d", e.y_speed, $signed(w[31:16]));
                errors++;
            end
            if (w[79:32] !== e.x_move) begin
                $error("x_move: expected %0d, got %0d", e.x_move, $signed(w[79:32]));
                errors++;
            end
            if (w[127:80] !== e.y_move) begin
                $error("y_move: expected %0d, got %0d", e.y_move, $signed(w[127:80]));
                errors++;
            end
            if (w[128] !== e.holding) begin
                $error("holding: expected %0d, got %0d", e.holding, w[128]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // now_us[31:0], x_raw[47:32], y_raw[63:48], stick_roll[79:64], stick_pitch[95:80]
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // x_speed[15:0], y_speed[31:16], x_move[79:32], y_move[127:80], holding[128]
    logic [135:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    speed_scoreboard sb;
    int          cycles;
    bit          quiet;
    bit          long_hold;
    logic [31:0] next_stamp;
    int          samples;

    flow_speed_smoother_integrator_core dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        m_tready <= 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_CENTER:   sb.center = value[15:0];
            REG_DEADBAND: sb.deadband = value[14:0];
            default:      sb.tau_us = value[19:0];
        endcase
    endtask

    task automatic send_sample(logic [31:0] now, logic [15:0] xr, logic [15:0] yr,
                               logic [15:0] roll, logic [15:0] pitch);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {pitch, roll, yr, xr, now};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample({pitch, roll, yr, xr, now});
        samples++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_stick();
        int span;
        span = 2 * int'(sb.deadband) + 2;
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return sb.center + 16'($urandom_range(0, 2 * span)) - 16'(span);
    endfunction

    task automatic random_sample();
        int sel;
        logic [15:0] xr;
        logic [15:0] yr;
        sel = $urandom_range(0, 99);
        if (sel < 84) next_stamp = next_stamp + $urandom_range(0, 3000);
        else if (sel < 92) next_stamp = next_stamp + $urandom_range(0, 1 << 20);
        else next_stamp = $urandom;
        if ($urandom_range(0, 1)) begin
            xr = 16'($urandom);
            yr = 16'($urandom);
        end else begin
            xr = 16'($urandom_range(0, 400)) - 16'd200;
            yr = 16'($urandom_range(0, 400)) - 16'd200;
        end
        send_sample(next_stamp, xr, yr, pick_stick(), pick_stick());
    endtask

    initial begin
        logic [15:0] centers[NUM_PHASES] = '{16'd1500, 16'd0, 16'd65535, 16'd1500,
                                             16'd32768, 16'd1000};
        logic [14:0] bands[NUM_PHASES] = '{15'd35, 15'd0, 15'd32767, 15'd35, 15'd1, 15'd300};
        logic [19:0] taus[NUM_PHASES] = '{20'd15916, 20'd0, 20'd1, 20'd1000000,
                                          20'hFFFFF, 20'd200};
        int per_phase;
        sb = new();
        quiet = 0;
        long_hold = 0;
        samples = 0;
        next_stamp = 0;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // first sample, equal stamp, backwards stamp, extreme raw values
        send_sample(32'd1000, 16'h7FFF, 16'h8000, 16'd1500, 16'd1500);
        send_sample(32'd1000, 16'h7FFF, 16'h8000, 16'd1500, 16'd1500);
        send_sample(32'd1400, 16'h8000, 16'h7FFF, 16'd1534, 16'd1466);
        send_sample(32'd1401, 16'hFFFF, 16'h0001, 16'd1535, 16'd1500);
        send_sample(32'd900, 16'h1234, 16'h4321, 16'd1500, 16'd1500);
        send_sample(32'd2000, 16'h0000, 16'h0000, 16'd1465, 16'd1500);
        send_sample(32'd2500, 16'h0100, 16'hFF00, 16'hFFFF, 16'h0000);
        drain();
        // saturate the position with huge steps and a fast filter
        reg_write(REG_TAU, 32'd1);
        for (int k = 0; k < 6; k++) begin
            send_sample(32'd0, 16'h7FFF, 16'h8000, 16'd1500, 16'd1500);
            send_sample(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'd1500, 16'd1500);
        end
        drain();
        reg_write(REG_TAU, 32'(TAU_RST));

        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            reg_write(REG_CENTER, 32'(centers[p]));
            reg_write(REG_DEADBAND, 32'(bands[p]));
            reg_write(REG_TAU, 32'(taus[p]));
            for (int i = 0; i < per_phase; i++) begin
                if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
                if (p == NUM_PHASES - 1 && i > per_phase - 150) quiet = 1;
                if (p == 2 && i == 40) long_hold = 1;
                if (p == 3 && i == 60) drain();
                random_sample();
            end
        end
        drain();

        $display("checked %0d result words from %0d samples, %0d while holding, %0d settings",
                 sb.checked, samples, sb.holds, NUM_PHASES);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
